>>> rtl/vmm_pkg.sv
// ----------------------------------------------------------------------------
// vmm_pkg: shared constants for the vector-matrix multiply core
// Field widths, register indexes and default sizing.
// ----------------------------------------------------------------------------
package vmm_pkg;

   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 16;
   localparam int QUEUE_DEPTH  = 4;

   localparam int VALUE_W    = 16;
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 48;
   localparam int COLIDX_W   = 4;
   localparam int ROWS_CFG_W = 7;
   localparam int COLS_CFG_W = 5;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS_IN_USE = 2'd1;

endpackage

>>> rtl/vmm_stream_if.sv
// ----------------------------------------------------------------------------
// vmm stream interfaces
// Request channel (vector and matrix element) and response channel (sums).
// ----------------------------------------------------------------------------
interface vmm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vmm_pkg::VALUE_W-1:0]    vec_value;
   logic signed [vmm_pkg::VALUE_W-1:0]    mat_value;

   modport source (output valid, output vec_value, output mat_value, input ready);
   modport sink   (input valid, input vec_value, input mat_value, output ready);
endinterface

interface vmm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vmm_pkg::SUM_W-1:0]      sum_value;
   logic        [vmm_pkg::COLIDX_W-1:0]   column_index;
   logic                                  last_result;

   modport source (output valid, output sum_value, output column_index,
                   output last_result, input ready);
   modport sink   (input valid, input sum_value, input column_index,
                   input last_result, output ready);
endinterface

>>> rtl/vmm_queue.sv
// ----------------------------------------------------------------------------
// vmm_queue: small FIFO between the front and back parts
// Registered storage, first-word-fall-through read.
// ----------------------------------------------------------------------------
module vmm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = vmm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             flush,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/vmm_front.sv
// ----------------------------------------------------------------------------
// vmm_front: request intake and classification
// Tracks row and column of each item and tags the final item of a run.
// ----------------------------------------------------------------------------
module vmm_front #(
   parameter int MAX_ROWS = vmm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = vmm_pkg::DEF_MAX_COLS,
   parameter int RW       = 7,
   parameter int CW       = 5,
   parameter int CIW      = 4,
   parameter int ENTRY_W  = 2 * vmm_pkg::VALUE_W + CIW + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic [RW-1:0]      rows_eff,
   input  logic [CW-1:0]      cols_eff,
   vmm_req_if.sink            req_ch,
   input  logic               q_full,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_data
);

   localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic [RIW-1:0] row_ff, row_in;
   logic [CIW-1:0] col_ff, col_in;
   logic           col_last, row_last, accept;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;
   assign q_push       = accept;

   assign col_last = (CW'(col_ff) + CW'(1)) >= cols_eff;
   assign row_last = (RW'(row_ff) + RW'(1)) >= rows_eff;

   assign q_data = {req_ch.vec_value, req_ch.mat_value, col_ff, col_last && row_last};

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + RIW'(1);
         end else begin
            col_in = col_ff + CIW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

>>> rtl/vmm_back.sv
// ----------------------------------------------------------------------------
// vmm_back: multiply-accumulate and column drain
// Multiplies queued items, accumulates per column, streams sums at run end.
// ----------------------------------------------------------------------------
module vmm_back #(
   parameter int MAX_COLS = vmm_pkg::DEF_MAX_COLS,
   parameter int CW       = 5,
   parameter int CIW      = 4,
   parameter int ENTRY_W  = 2 * vmm_pkg::VALUE_W + CIW + 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic [CW-1:0]      cols_eff,
   input  logic               q_empty,
   input  logic [ENTRY_W-1:0] q_data,
   output logic               q_pop,
   vmm_rsp_if.source          rsp_ch
);

   localparam int VW = vmm_pkg::VALUE_W;
   localparam int PW = vmm_pkg::PROD_W;
   localparam int SW = vmm_pkg::SUM_W;

   localparam logic ST_ACC   = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic signed [VW-1:0] a_vec, a_mat;
   logic [CIW-1:0]       a_col;
   logic                 a_drain;

   logic                 state_ff, state_in;

   // accumulate stage
   logic                 b_vld_ff, b_drain_ff;
   logic [CIW-1:0]       b_col_ff;
   logic signed [PW-1:0] b_prod_ff, b_prod_in;

   // accumulator memory and its registered read
   logic [SW-1:0]        acc_mem [MAX_COLS];
   logic [MAX_COLS-1:0]  acc_vld_ff;
   logic [SW-1:0]        rd_ff;
   logic                 rd_vld_ff;
   logic [CIW-1:0]       rd_addr;

   // last write, for back-to-back hits on one column
   logic                 fw_vld_ff;
   logic [CIW-1:0]       fw_col_ff;
   logic [SW-1:0]        fw_data_ff;

   logic [SW-1:0]        old_sum, new_sum;

   // drain sequencer
   logic [CIW-1:0]       drain_ptr_ff, drain_ptr_in;
   logic                 inflight_ff, inflight_in;
   logic [CIW-1:0]       ld_col_ff;
   logic                 ld_last_ff;
   logic                 issue, issue_last;

   // output register
   logic                 out_vld_ff, out_vld_in;
   logic [SW-1:0]        out_sum_ff;
   logic [CIW-1:0]       out_col_ff;
   logic                 out_last_ff;

   assign {a_vec, a_mat, a_col, a_drain} = q_data;

   // hold intake while a run-ending item is in the accumulate stage or a run drains
   assign q_pop = !q_empty && (state_ff == ST_ACC) && !(b_vld_ff && b_drain_ff);

   assign b_prod_in = a_vec * a_mat;
   assign rd_addr   = (state_ff == ST_ACC) ? a_col : drain_ptr_ff;

   always_comb begin
      if (fw_vld_ff && (fw_col_ff == b_col_ff)) begin
         old_sum = fw_data_ff;
      end else if (rd_vld_ff) begin
         old_sum = rd_ff;
      end else begin
         old_sum = '0;
      end
      new_sum = old_sum + SW'(b_prod_ff);
   end

   assign issue_last = (CW'(drain_ptr_ff) == (cols_eff - CW'(1)));
   assign issue      = (state_ff == ST_DRAIN) && !inflight_ff && (!out_vld_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      drain_ptr_in = drain_ptr_ff;
      inflight_in  = issue;
      out_vld_in   = out_vld_ff;
      if (b_vld_ff && b_drain_ff) begin
         state_in     = ST_DRAIN;
         drain_ptr_in = '0;
      end else if (issue) begin
         drain_ptr_in = drain_ptr_ff + CIW'(1);
         if (issue_last) begin
            state_in = ST_ACC;
         end
      end
      if (inflight_ff) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff     <= ST_ACC;
         b_vld_ff     <= 1'b0;
         fw_vld_ff    <= 1'b0;
         inflight_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
         drain_ptr_ff <= '0;
         acc_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         b_vld_ff     <= q_pop;
         fw_vld_ff    <= b_vld_ff;
         inflight_ff  <= inflight_in;
         out_vld_ff   <= out_vld_in;
         drain_ptr_ff <= drain_ptr_in;
         if (b_vld_ff) begin
            acc_vld_ff[b_col_ff] <= 1'b1;
         end
         // drop each column as it is read out
         if (issue) begin
            acc_vld_ff[drain_ptr_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      b_drain_ff <= a_drain;
      b_col_ff   <= a_col;
      b_prod_ff  <= b_prod_in;
      fw_col_ff  <= b_col_ff;
      fw_data_ff <= new_sum;
      ld_col_ff  <= drain_ptr_ff;
      ld_last_ff <= issue_last;
      if (b_vld_ff) begin
         acc_mem[b_col_ff] <= new_sum;
      end
      rd_ff     <= acc_mem[rd_addr];
      rd_vld_ff <= acc_vld_ff[rd_addr];
      if (inflight_ff) begin
         out_sum_ff  <= rd_vld_ff ? rd_ff : '0;
         out_col_ff  <= ld_col_ff;
         out_last_ff <= ld_last_ff;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.sum_value    = out_sum_ff;
   assign rsp_ch.column_index = vmm_pkg::COLIDX_W'(out_col_ff);
   assign rsp_ch.last_result  = out_last_ff;

endmodule

>>> rtl/vector_matrix_multiply_core.sv
// Path: with an empty queue, the final item of a run goes through the queue and the
// accumulate stage and starts the drain, which reads the column sums out one at a time.
// Throughput: one item per cycle, set by the multiply-accumulate stage; the back takes
// no queued items while a run drains, and intake stalls once the queue is full.
// Reset: counters cleared, accumulators marked empty at once through per-column valid bits.
// ----------------------------------------------------------------------------
// vector_matrix_multiply_core: row vector times matrix, per-column sums
// Front classifies items, a queue decouples it from the accumulate/drain back.
// ----------------------------------------------------------------------------
module vector_matrix_multiply_core #(
   parameter int MAX_ROWS = vmm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = vmm_pkg::DEF_MAX_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   vmm_req_if.sink                             req_ch,
   vmm_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [vmm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vmm_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int RCW     = $clog2(MAX_ROWS + 1);
   localparam int CCW     = $clog2(MAX_COLS + 1);
   localparam int RW      = (RCW > vmm_pkg::ROWS_CFG_W) ? RCW : vmm_pkg::ROWS_CFG_W;
   localparam int CW      = (CCW > vmm_pkg::COLS_CFG_W) ? CCW : vmm_pkg::COLS_CFG_W;
   localparam int CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ENTRY_W = 2 * vmm_pkg::VALUE_W + CIW + 1;

   logic [vmm_pkg::ROWS_CFG_W-1:0] rows_cfg_ff;
   logic [vmm_pkg::COLS_CFG_W-1:0] cols_cfg_ff;
   logic [RW-1:0]                  rows_eff;
   logic [CW-1:0]                  cols_eff;
   logic                           wr_rows, wr_cols, restart;

   logic               q_push, q_pop, q_full, q_empty;
   logic [ENTRY_W-1:0] q_in_data, q_out_data;

   assign wr_rows = csr_write_enable && (csr_index == vmm_pkg::REG_ROWS_IN_USE);
   assign wr_cols = csr_write_enable && (csr_index == vmm_pkg::REG_COLS_IN_USE);
   assign restart = wr_rows || wr_cols;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= vmm_pkg::ROWS_CFG_W'(64);
         cols_cfg_ff <= vmm_pkg::COLS_CFG_W'(16);
      end else begin
         if (wr_rows) begin
            rows_cfg_ff <= csr_write_data[vmm_pkg::ROWS_CFG_W-1:0];
         end
         if (wr_cols) begin
            cols_cfg_ff <= csr_write_data[vmm_pkg::COLS_CFG_W-1:0];
         end
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      priority if (rows_cfg_ff == '0) begin
         rows_eff = RW'(1);
      end else if (RW'(rows_cfg_ff) > RW'(MAX_ROWS)) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(rows_cfg_ff);
      end
      priority if (cols_cfg_ff == '0) begin
         cols_eff = CW'(1);
      end else if (CW'(cols_cfg_ff) > CW'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_cfg_ff);
      end
   end

   vmm_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .RW       (RW),
      .CW       (CW),
      .CIW      (CIW),
      .ENTRY_W  (ENTRY_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .rows_eff (rows_eff),
      .cols_eff (cols_eff),
      .req_ch   (req_ch),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   vmm_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (vmm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .flush     (restart),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   vmm_back #(
      .MAX_COLS (MAX_COLS),
      .CW       (CW),
      .CIW      (CIW),
      .ENTRY_W  (ENTRY_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .restart  (restart),
      .cols_eff (cols_eff),
      .q_empty  (q_empty),
      .q_data   (q_out_data),
      .q_pop    (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
